>>> src/wto_pkg.sv
// Shared types, constants and register codes for the wavetable octave oscillator.
`default_nettype none
package wto_pkg;

  localparam int SAMPLE_COUNT_DEF = 256;
  localparam int OCTAVE_COUNT_DEF = 8;
  localparam int WAVE_COUNT_DEF   = 4;

  localparam int STORE_AW  = 13;
  localparam int FRAC_BITS = 24;

  // register indexes
  localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] REG_MIN_FREQ    = 2'd1;
  localparam logic [1:0] REG_MAX_FREQ    = 2'd2;

  localparam logic [17:0] SAMPLE_RATE_RST = 18'd48000;
  localparam logic [14:0] MIN_FREQ_RST    = 15'd20;
  localparam logic [15:0] MAX_FREQ_RST    = 16'd2560;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [23:0]        freq;
    logic [1:0]         wave_select;
    logic [12:0]        table_address;
    logic signed [15:0] table_data;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [17:0] data;
  } cfg_item_t;

endpackage
`default_nettype wire

>>> src/wto_stream_if.sv
// Valid/ready channel carrying one payload beat.
`default_nettype none
interface wto_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/wto_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module wto_div #(
  parameter int NW = 48,
  parameter int DW = 18
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               busy,
  output logic [NW-1:0]      quotient
);
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    trial   = {rem_r, q_r[NW-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
    q_nxt   = {q_r[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

>>> src/wavetable_octave_oscillator.sv
// Wavetable oscillator with octave crossfade: control, wave store and interpolation.
// A table write goes straight into the store. A tick runs two bit-serial dividers side
// by side: the phase step divide starts when the tick is accepted, while the octave
// band search runs first and then starts the crossfade divide. Four reads through the
// store's single read port, the mix states S_MIXA, S_MIXB and S_MIXC and an output
// state follow once both divides are done. SAMPLE_COUNT must be a power of two. The
// result sits in an output register; the next item is taken while it waits.
`default_nettype none
module wavetable_octave_oscillator #(
  parameter int SAMPLE_COUNT = wto_pkg::SAMPLE_COUNT_DEF,
  parameter int OCTAVE_COUNT = wto_pkg::OCTAVE_COUNT_DEF,
  parameter int WAVE_COUNT   = wto_pkg::WAVE_COUNT_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  wto_stream_if.sink   in_chan,
  wto_stream_if.source out_chan,
  wto_stream_if.sink   cfg_chan
);
  import wto_pkg::*;

  localparam int SB = $clog2(SAMPLE_COUNT);
  localparam int PW = FRAC_BITS + SB;
  localparam int NW = FRAC_BITS + 16 + SB;
  localparam int AW = 40;
  localparam int STORE_DEPTH = 1 << STORE_AW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BAND = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_MIXA = 3'd4;
  localparam logic [2:0] S_MIXB = 3'd5;
  localparam logic [2:0] S_MIXC = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]  state_r;
  logic [17:0] rate_r;
  logic [14:0] minf_r;
  logic [15:0] maxf_r;
  logic [PW-1:0] phase_r;

  logic [23:0] fc_r;
  logic [1:0]  wave_r;
  logic [23:0] p_r;
  logic [3:0]  band_r;
  logic [15:0] amt_r;
  logic [4:0]  oct1_r, oct2_r;
  logic [2:0]  rd_cnt_r;

  logic signed [15:0] smp_r [4];
  logic signed [33:0] m0_r, m1_r;
  logic signed [15:0] y0_r, y1_r;
  logic signed [41:0] m2_r;

  logic signed [15:0] mem_q_r;
  logic signed [15:0] wave_mem [STORE_DEPTH];

  out_item_t out_r;
  logic      out_valid_r;
  logic      out_load;

  in_item_t  item;
  logic      in_fire;
  logic      tick_fire;
  logic      wr_fire;

  assign item      = in_chan.data;
  assign in_fire   = in_chan.valid && in_chan.ready;
  assign tick_fire = in_fire && (item.req_type == REQ_TICK);
  assign wr_fire   = in_fire && (item.req_type == REQ_WRITE);

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  // result register takes a new beat once the old one is gone
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= SAMPLE_RATE_RST;
      minf_r <= MIN_FREQ_RST;
      maxf_r <= MAX_FREQ_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.data.index)
        REG_SAMPLE_RATE: rate_r <= cfg_chan.data.data;
        REG_MIN_FREQ:    minf_r <= cfg_chan.data.data[14:0];
        REG_MAX_FREQ:    maxf_r <= cfg_chan.data.data[15:0];
        default: ;
      endcase
    end
  end

  // clamp and divider operands
  logic [22:0] lo;
  logic [23:0] hi;
  logic [23:0] fc_in;
  logic [17:0] rate_eff;

  always_comb begin
    lo       = {(minf_r == '0) ? 15'd1 : minf_r, 8'd0};
    hi       = {maxf_r, 8'd0};
    fc_in    = (item.freq < {1'b0, lo}) ? {1'b0, lo} : item.freq;
    if (fc_in > hi) fc_in = hi;
    rate_eff = (rate_r == '0) ? 18'd1 : rate_r;
  end

  logic          pdiv_busy;
  logic [NW-1:0] pdiv_q;

  wto_div #(.NW(NW), .DW(18)) u_pdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (tick_fire),
    .dividend ({item.freq, {(16 + SB){1'b0}}}),
    .divisor  (rate_eff),
    .busy     (pdiv_busy),
    .quotient (pdiv_q)
  );

  logic [24:0]   p_dbl;
  logic          band_go;
  logic          adiv_start;
  logic [23:0]   fc_gap;
  logic          adiv_busy;
  logic [AW-1:0] adiv_q;

  always_comb begin
    p_dbl      = {p_r, 1'b0};
    band_go    = (p_dbl <= {1'b0, fc_r}) && (band_r != 4'd15);
    adiv_start = (state_r == S_BAND) && !band_go;
    fc_gap     = (fc_r > p_r) ? (fc_r - p_r) : 24'd0;
  end

  wto_div #(.NW(AW), .DW(24)) u_adiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (adiv_start),
    .dividend ({fc_gap, 16'd0}),
    .divisor  (p_r),
    .busy     (adiv_busy),
    .quotient (adiv_q)
  );

  // store addressing
  logic [SB-1:0]       s0, s1, s_sel;
  logic [4:0]          oct_sel;
  logic [31:0]         tbl_idx;
  logic [STORE_AW-1:0] rd_addr;
  logic [4:0]          oct1_nxt, oct2_nxt;

  always_comb begin
    s0       = phase_r[PW-1:FRAC_BITS];
    s1       = s0 + 1'b1;
    s_sel    = rd_cnt_r[1] ? s1 : s0;
    oct_sel  = rd_cnt_r[0] ? oct2_r : oct1_r;
    tbl_idx  = 32'(OCTAVE_COUNT) * 32'(wave_r) + 32'(oct_sel);
    rd_addr  = STORE_AW'((tbl_idx << SB) + 32'(s_sel));
    oct1_nxt = ({1'b0, band_r} + 5'd1 > 5'(OCTAVE_COUNT - 1)) ?
               5'(OCTAVE_COUNT - 1) : {1'b0, band_r} + 5'd1;
    oct2_nxt = (oct1_nxt + 5'd1 > 5'(OCTAVE_COUNT - 1)) ?
               5'(OCTAVE_COUNT - 1) : oct1_nxt + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (wr_fire) wave_mem[item.table_address] <= item.table_data;
    mem_q_r <= wave_mem[rd_addr];
  end

  // mix arithmetic
  logic signed [16:0] d0, d1, d2;
  logic signed [17:0] y0_sum, y1_sum, out_sum;

  always_comb begin
    d0      = 17'(smp_r[1]) - 17'(smp_r[0]);
    d1      = 17'(smp_r[3]) - 17'(smp_r[2]);
    d2      = 17'(y1_r) - 17'(y0_r);
    y0_sum  = 18'(smp_r[0]) + 18'(m0_r >>> 16);
    y1_sum  = 18'(smp_r[2]) + 18'(m1_r >>> 16);
    out_sum = 18'(y0_r) + 18'(m2_r >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      rd_cnt_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (tick_fire) begin
            fc_r    <= fc_in;
            wave_r  <= (32'(item.wave_select) > 32'(WAVE_COUNT - 1)) ?
                       2'(WAVE_COUNT - 1) : item.wave_select;
            p_r     <= {1'b0, lo};
            band_r  <= '0;
            state_r <= S_BAND;
          end
        end
        S_BAND: begin
          if (band_go) begin
            p_r    <= p_dbl[23:0];
            band_r <= band_r + 1'b1;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (!pdiv_busy && !adiv_busy) begin
            phase_r  <= phase_r + pdiv_q[PW-1:0];
            amt_r    <= (adiv_q[AW-1:16] != '0) ? 16'hFFFF : adiv_q[15:0];
            oct1_r   <= oct1_nxt;
            oct2_r   <= oct2_nxt;
            rd_cnt_r <= '0;
            state_r  <= S_READ;
          end
        end
        S_READ: begin
          // address k goes out at count k, its registered word is captured at count k+1
          if (rd_cnt_r != 3'd0) smp_r[rd_cnt_r[1:0] - 2'd1] <= mem_q_r;
          if (rd_cnt_r == 3'd4) begin
            rd_cnt_r <= '0;
            state_r  <= S_MIXA;
          end else begin
            rd_cnt_r <= rd_cnt_r + 1'b1;
          end
        end
        S_MIXA: begin
          m0_r    <= d0 * $signed({1'b0, amt_r});
          m1_r    <= d1 * $signed({1'b0, amt_r});
          state_r <= S_MIXB;
        end
        S_MIXB: begin
          y0_r    <= y0_sum[15:0];
          y1_r    <= y1_sum[15:0];
          state_r <= S_MIXC;
        end
        S_MIXC: begin
          m2_r    <= d2 * $signed({1'b0, phase_r[FRAC_BITS-1:0]});
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) out_r.sample <= out_sum[15:0];
  end

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!pdiv_busy && !adiv_busy))
    else $error("divider busy while idle");

  a_rd_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_READ) |-> (rd_cnt_r == 3'd0))
    else $error("read counter active outside read phase");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside done state");

  a_band: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BAND && band_r != 4'd0) |-> (p_r <= fc_r))
    else $error("band base exceeds clamped frequency");

endmodule
`default_nettype wire

>>> tb/wto_checker.sv
`timescale 1ns / 100ps
// Watches the oscillator channels, predicts each tick's sample and compares it with the output.
module wto_checker (
  input  logic   clk,
  input  logic   rst_n,
  wto_stream_if  in_mon,
  wto_stream_if  out_mon,
  wto_stream_if  cfg_mon,
  output int     fails,
  output int     pending
);
  import wto_pkg::*;

  localparam int NSAMP = 256;
  localparam int NOCT  = 8;
  localparam int NWAVE = 4;

  logic [17:0]        rate_reg;
  logic [14:0]        minf_reg;
  logic [15:0]        maxf_reg;
  logic [31:0]        phase_acc;
  logic signed [15:0] wave_mem [0:8191];
  logic signed [15:0] expected_samples [$];

  function automatic logic signed [15:0] blend(longint a, longint b, longint t, int sh);
    longint one;
    longint sum;
    one = longint'(1) << sh;
    sum = a * (one - t) + b * t;
    return 16'(sum >>> sh);
  endfunction

  function automatic longint mem_rd(int w, int oct, int s);
    return longint'(wave_mem[(NSAMP * (NOCT * w + oct) + s) & 8191]);
  endfunction

  // advances the phase and returns the crossfaded, interpolated sample
  function automatic logic signed [15:0] tick_sample(in_item_t it);
    longint unsigned rate, mf, lo, hi, fc, x, p, amt, inc, frac;
    int band, o1, o2, s0, s1, w;
    longint y0, y1;
    rate = (rate_reg == 0) ? 1 : rate_reg;
    mf   = (minf_reg == 0) ? 1 : minf_reg;
    inc  = (longint'(it.freq) << 24) / rate;
    phase_acc = phase_acc + inc[31:0];
    lo = mf << 8;
    hi = longint'(maxf_reg) << 8;
    fc = it.freq;
    if (fc < lo) fc = lo;
    if (fc > hi) fc = hi;
    x = fc / lo;
    band = 0;
    while (x > 1) begin
      x = x >> 1;
      band++;
    end
    o1 = (band + 1 > NOCT - 1) ? NOCT - 1 : band + 1;
    o2 = (o1 + 1 > NOCT - 1) ? NOCT - 1 : o1 + 1;
    p = lo << band;
    if (fc <= p) amt = 0;
    else begin
      amt = ((fc - p) << 16) / p;
      if (amt > 65535) amt = 65535;
    end
    w = (it.wave_select > NWAVE - 1) ? NWAVE - 1 : it.wave_select;
    s0 = phase_acc[31:24] % NSAMP;
    s1 = (s0 + 1) % NSAMP;
    frac = phase_acc[23:0];
    y0 = blend(mem_rd(w, o1, s0), mem_rd(w, o2, s0), amt, 16);
    y1 = blend(mem_rd(w, o1, s1), mem_rd(w, o2, s1), amt, 16);
    return blend(y0, y1, frac, FRAC_BITS);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rate_reg  = SAMPLE_RATE_RST;
      minf_reg  = MIN_FREQ_RST;
      maxf_reg  = MAX_FREQ_RST;
      phase_acc = '0;
      expected_samples.delete();
      fails = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_samples.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected output beat: sample %0d", out_mon.data.sample);
        end else begin
          logic signed [15:0] want;
          want = expected_samples.pop_front();
          if (out_mon.data.sample !== want) begin
            fails++;
            if (fails <= 10)
              $display("sample mismatch: expected %0d got %0d", want, out_mon.data.sample);
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.data.index)
          REG_SAMPLE_RATE: rate_reg = cfg_mon.data.data;
          REG_MIN_FREQ:    minf_reg = cfg_mon.data.data[14:0];
          REG_MAX_FREQ:    maxf_reg = cfg_mon.data.data[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.data.req_type == REQ_WRITE)
          wave_mem[in_mon.data.table_address] = in_mon.data.table_data;
        else
          expected_samples.push_back(tick_sample(in_mon.data));
      end
    end
    pending = expected_samples.size();
  end
endmodule

>>> tb/wavetable_octave_oscillator_tb.sv
`timescale 1ns / 100ps
// Top of the oscillator testbench: clock, reset, stimulus, stalls and verdict.
module wavetable_octave_oscillator_tb;
  import wto_pkg::*;

  localparam int LIMIT = 2000000;

  logic clk;
  logic rst_n;
  int   fails;
  int   pending;
  int   cycles;
  bit   calm;
  int   out_hold;
  logic [15:0] cur_max;
  logic [14:0] cur_min;

  wto_stream_if #(.T(in_item_t))  in_chan ();
  wto_stream_if #(.T(out_item_t)) out_chan ();
  wto_stream_if #(.T(cfg_item_t)) cfg_chan ();

  wavetable_octave_oscillator dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan), .cfg_chan(cfg_chan)
  );

  wto_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan), .cfg_mon(cfg_chan),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 0;
    rst_n = 0;
    in_chan.valid = 0;
    in_chan.data = '0;
    out_chan.ready = 0;
    cfg_chan.valid = 0;
    cfg_chan.data = '0;
  end

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end
  initial cycles = 0;

  // receiver stalls: a random hold after each beat unless calm
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 0;
      out_hold <= 0;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_chan.ready <= (out_hold == 1);
    end else if (out_chan.valid && out_chan.ready) begin
      int n;
      n = calm ? 0 : $urandom_range(0, 17);
      out_hold <= n;
      out_chan.ready <= (n == 0);
    end else begin
      out_chan.ready <= 1;
    end
  end

  task automatic send(in_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_chan.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1;
    in_chan.data <= it;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic send_tick(logic [23:0] f, logic [1:0] w);
    in_item_t it;
    it = '0;
    it.req_type = REQ_TICK;
    it.freq = f;
    it.wave_select = w;
    it.table_address = 13'($urandom);
    it.table_data = 16'($urandom);
    send(it);
  endtask

  task automatic send_write(logic [12:0] a, logic signed [15:0] d);
    in_item_t it;
    it = '0;
    it.req_type = REQ_WRITE;
    it.freq = 24'($urandom);
    it.wave_select = 2'($urandom);
    it.table_address = a;
    it.table_data = d;
    send(it);
  endtask

  // quiesce: all samples back, then let any trailing write finish
  task automatic drain();
    in_chan.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [17:0] val);
    cfg_chan.valid <= 1;
    cfg_chan.data <= '{index: idx, data: val};
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 0;
    @(posedge clk);
    if (idx == REG_MIN_FREQ) cur_min = val[14:0];
    if (idx == REG_MAX_FREQ) cur_max = val[15:0];
  endtask

  logic [17:0] rates [5] = '{18'd192000, 18'd8000, 18'd0, 18'd44100, 18'd48000};
  logic [14:0] mins  [5] = '{15'd1, 15'd20000, 15'd0, 15'd55, 15'd20};
  logic [15:0] maxs  [5] = '{16'd65535, 16'd1, 16'd20000, 16'd7040, 16'd2560};

  initial begin
    logic [23:0] f;
    logic [31:0] top_f;
    cur_min = MIN_FREQ_RST;
    cur_max = MAX_FREQ_RST;
    calm = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // load every store word before any tick can read it
    calm = 1;
    for (int a = 0; a < 8192; a++) send_write(13'(a), 16'($urandom));
    calm = 0;

    // directed beats under reset settings
    send_write(13'd0, 16'sh8000);
    send_write(13'd8191, 16'sh7fff);
    send_tick(24'd0, 2'd0);
    send_tick(24'hffffff, 2'd3);
    send_tick(24'd5120, 2'd1);
    send_tick(24'd655360, 2'd2);
    send_tick(24'd10240, 2'd0);
    send_tick(24'd7000, 2'd3);
    send_tick(24'd100000, 2'd1);
    send_tick(24'(2560 * 256 - 1), 2'd2);
    send_tick(24'h800000, 2'd0);
    send_tick(24'h7fffff, 2'd1);
    drain();
    write_reg(2'd3, 18'h3ffff);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(REG_SAMPLE_RATE, rates[ph]);
      write_reg(REG_MIN_FREQ, 18'(mins[ph]));
      write_reg(REG_MAX_FREQ, 18'(maxs[ph]));
      for (int i = 0; i < 200; i++) begin
        if (i % 50 == 0) calm = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 4) == 0)
          send_write(13'($urandom), 16'($urandom));
        else begin
          top_f = {cur_max > cur_min ? cur_max : {1'b0, cur_min}, 8'd0} * 2;
          if ($urandom_range(0, 3) == 0 || top_f > 32'hffffff) f = 24'($urandom);
          else f = 24'($urandom_range(0, top_f));
          send_tick(f, 2'($urandom));
        end
      end
      calm = 0;
    end
    drain();

    if (fails == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

>>> wavetable_octave_oscillator.f
src/wto_pkg.sv
src/wto_stream_if.sv
src/wto_div.sv
src/wavetable_octave_oscillator.sv
tb/wto_checker.sv
tb/wavetable_octave_oscillator_tb.sv
